FILE: src/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define VPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/vpt_pkg.sv
// Viewport transform package: request types, register indexes, helpers.
// No dependencies.
package vpt_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int QUO_W  = 32;   // quotient bits produced by each divider
  localparam int SCR_NW = 50;   // screen numerator magnitude width
  localparam int DEP_NW = 65;   // depth / inverse-w numerator magnitude width
  localparam int DEN_W  = 33;   // divider denominator width

  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_VIEW_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_DEPTH_NEAR  = 3'd4;
  localparam logic [2:0] CFG_DEPTH_FAR   = 3'd5;
  localparam logic [2:0] CFG_POINT_MODE  = 3'd6;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [31:0] depth;
    logic signed [31:0] inv_w;
    logic               div_fault;
  } vtx_out_t;

  typedef struct packed {
    logic        neg;
    logic [64:0] m;
  } magsum_t;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Signed sum of two sign/magnitude terms, back in sign/magnitude form.
  function automatic magsum_t add_mag(logic [64:0] a, logic na, logic [64:0] b, logic nb);
    magsum_t     r;
    logic [64:0] d_ab;
    logic [64:0] d_ba;
    d_ab = a - b;
    d_ba = b - a;
    if (na == nb) begin
      r.m   = a + b;
      r.neg = na;
    end else if (a >= b) begin
      r.m   = d_ab;
      r.neg = na;
    end else begin
      r.m   = d_ba;
      r.neg = nb;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16(logic [QUO_W-1:0] q, logic ovf, logic nz, logic neg);
    logic [QUO_W-1:0] nq;
    nq = ~q + 1'b1;
    if (!nz) return 16'd0;
    if (neg) return (ovf || q > QUO_W'(32768)) ? 16'h8000 : nq[15:0];
    return (ovf || q > QUO_W'(32767)) ? 16'h7fff : q[15:0];
  endfunction

  function automatic logic [31:0] sat32(logic [QUO_W-1:0] q, logic ovf, logic nz, logic neg);
    logic [QUO_W-1:0] nq;
    nq = ~q + 1'b1;
    if (!nz) return 32'd0;
    if (neg) return (ovf || q > QUO_W'(33'h080000000)) ? 32'h80000000 : nq[31:0];
    return (ovf || q > QUO_W'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
  endfunction

endpackage

FILE: src/viewport_transform_top.sv
// Viewport transform top level: perspective divide and viewport mapping.
// Depends on vpt_pkg, vpt_div and assert_macros.svh.
//
//   channel  ports                         direction  payload
//   input    in_valid  in_stall  in_data    in         vtx_in_t
//   result   out_valid out_stall out_data   out        vtx_out_t
//   config   cfg_we    cfg_idx   cfg_wdata  in         register write
//
// One vertex per cycle sustained while in_stall is low. 37 register stages, the
// first loaded at the accepting edge: 3 front stages (magnitudes, products,
// signed sums), 33 divider stages, the output register. Reset is synchronous,
// active low; it clears valid bits and config registers but sets depth_far_r
// to 1 << FRAC_BITS. A stalled result parks in the output register; one skid
// entry catches the request leaving the pipe; in_stall is its valid bit.
`include "assert_macros.svh"

module viewport_transform_top import vpt_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  vtx_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output vtx_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  localparam int          LAT     = QUO_W + 1;
  localparam logic [64:0] INV_NUM = 65'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic nx;
    logic ny;
    logic nd;
    logic wneg;
    logic wzero;
  } side_t;

  // configuration registers
  logic [15:0] origin_x_r, origin_y_r;
  logic [14:0] view_width_r, view_height_r;
  logic [31:0] depth_near_r, depth_far_r;
  logic        point_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      view_width_r  <= '0;
      view_height_r <= '0;
      depth_near_r  <= '0;
      depth_far_r   <= 32'(64'(1) << FRAC_BITS);
      point_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_X:    origin_x_r    <= cfg_wdata[15:0];
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_wdata[15:0];
        CFG_VIEW_WIDTH:  view_width_r  <= cfg_wdata[14:0];
        CFG_VIEW_HEIGHT: view_height_r <= cfg_wdata[14:0];
        CFG_DEPTH_NEAR:  depth_near_r  <= cfg_wdata;
        CFG_DEPTH_FAR:   depth_far_r   <= cfg_wdata;
        CFG_POINT_MODE:  point_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together; it halts only while the skid entry is full
  logic ce;
  logic skid_valid_r;
  assign ce       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // ---- stage A: magnitudes of inputs and of the viewport terms ----
  logic        in_wzero;
  logic [17:0] off2x_c, off2y_c;
  logic [32:0] dz_c, sum_c;
  assign in_wzero = (in_data.clip_w == 32'sd0);
  // 2*origin + size, exact doubled offset
  assign off2x_c = (18'(signed'(origin_x_r)) << 1) + 18'(view_width_r);
  assign off2y_c = (18'(signed'(origin_y_r)) << 1) + 18'(view_height_r);
  assign dz_c    = {depth_far_r[31], depth_far_r} - {depth_near_r[31], depth_near_r};
  assign sum_c   = {depth_far_r[31], depth_far_r} + {depth_near_r[31], depth_near_r};

  logic        a_valid_r;
  logic [31:0] a_ax_r, a_ay_r, a_az_r, a_aw_r;
  logic        a_xneg_r, a_yneg_r, a_zneg_r, a_wneg_r, a_wzero_r;
  logic [14:0] a_hwx_r, a_hwy_r;
  logic [16:0] a_offx_r, a_offy_r;
  logic        a_offxn_r, a_offyn_r;
  logic [31:0] a_dzm_r;
  logic        a_dzn_r;
  logic [32:0] a_summ_r;
  logic        a_sumn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (ce) begin
      // zero w in point mode: accepted and dropped
      a_valid_r <= in_valid && !(in_wzero && point_mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_ax_r    <= mag32(in_data.clip_x);
      a_ay_r    <= mag32(in_data.clip_y);
      a_az_r    <= mag32(in_data.clip_z);
      a_aw_r    <= mag32(in_data.clip_w);
      a_xneg_r  <= in_data.clip_x[31];
      a_yneg_r  <= in_data.clip_y[31];
      a_zneg_r  <= in_data.clip_z[31];
      a_wneg_r  <= in_data.clip_w[31];
      a_wzero_r <= in_wzero;
      a_hwx_r   <= {view_width_r[14:1], 1'b0};
      a_hwy_r   <= {view_height_r[14:1], 1'b0};
      a_offx_r  <= 17'(off2x_c[17] ? (~off2x_c + 18'd1) : off2x_c);
      a_offy_r  <= 17'(off2y_c[17] ? (~off2y_c + 18'd1) : off2y_c);
      a_offxn_r <= off2x_c[17];
      a_offyn_r <= off2y_c[17];
      a_dzm_r   <= 32'(dz_c[32] ? (~dz_c + 33'd1) : dz_c);
      a_dzn_r   <= dz_c[32];
      a_summ_r  <= sum_c[32] ? (~sum_c + 33'd1) : sum_c;
      a_sumn_r  <= sum_c[32];
    end
  end

  // ---- stage B: products ----
  logic        b_valid_r;
  logic [64:0] b_px1_r, b_px2_r, b_py1_r, b_py2_r, b_pd1_r, b_pd2_r;
  logic        b_sx1_r, b_sx2_r, b_sy1_r, b_sy2_r, b_sd1_r, b_sd2_r;
  logic [31:0] b_aw_r;
  logic        b_wneg_r, b_wzero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (ce) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_px1_r   <= 65'(a_hwx_r) * 65'(a_ax_r);
      b_px2_r   <= 65'(a_offx_r) * 65'(a_aw_r);
      b_py1_r   <= 65'(a_hwy_r) * 65'(a_ay_r);
      b_py2_r   <= 65'(a_offy_r) * 65'(a_aw_r);
      b_pd1_r   <= 65'(a_dzm_r) * 65'(a_az_r);
      b_pd2_r   <= 65'(a_summ_r) * 65'(a_aw_r);
      b_sx1_r   <= a_xneg_r ^ a_wneg_r;
      b_sx2_r   <= a_offxn_r;
      b_sy1_r   <= a_yneg_r ^ a_wneg_r;
      b_sy2_r   <= a_offyn_r;
      b_sd1_r   <= a_dzn_r ^ a_zneg_r ^ a_wneg_r;
      b_sd2_r   <= a_sumn_r;
      b_aw_r    <= a_aw_r;
      b_wneg_r  <= a_wneg_r;
      b_wzero_r <= a_wzero_r;
    end
  end

  // ---- stage C: signed numerators and denominators ----
  magsum_t sx_c, sy_c, sd_c;
  assign sx_c = add_mag(b_px1_r, b_sx1_r, b_px2_r, b_sx2_r);
  assign sy_c = add_mag(b_py1_r, b_sy1_r, b_py2_r, b_sy2_r);
  assign sd_c = add_mag(b_pd1_r, b_sd1_r, b_pd2_r, b_sd2_r);

  logic              c_valid_r;
  logic [SCR_NW-1:0] c_mx_r, c_my_r;
  logic [DEP_NW-1:0] c_md_r;
  logic [DEN_W-1:0]  c_den2_r, c_den1_r;
  side_t             c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (ce) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_mx_r         <= sx_c.m[SCR_NW-1:0];
      c_my_r         <= sy_c.m[SCR_NW-1:0];
      c_md_r         <= sd_c.m[DEP_NW-1:0];
      c_den2_r       <= {b_aw_r, 1'b0};
      c_den1_r       <= {1'b0, b_aw_r};
      c_side_r.nx    <= sx_c.neg;
      c_side_r.ny    <= sy_c.neg;
      c_side_r.nd    <= sd_c.neg;
      c_side_r.wneg  <= b_wneg_r;
      c_side_r.wzero <= b_wzero_r;
    end
  end

  // ---- divider stages ----
  logic [QUO_W-1:0] qx, qy, qd, qi;
  logic             ovfx, ovfy, ovfd, ovfi;
  logic             nzx, nzy, nzd, nzi;

  vpt_div #(.NW(SCR_NW), .DW(DEN_W), .QW(QUO_W)) u_div_x (
    .clk(clk), .ce(ce), .num(c_mx_r), .den(c_den2_r), .quo(qx), .ovf(ovfx), .nz(nzx)
  );
  vpt_div #(.NW(SCR_NW), .DW(DEN_W), .QW(QUO_W)) u_div_y (
    .clk(clk), .ce(ce), .num(c_my_r), .den(c_den2_r), .quo(qy), .ovf(ovfy), .nz(nzy)
  );
  vpt_div #(.NW(DEP_NW), .DW(DEN_W), .QW(QUO_W)) u_div_d (
    .clk(clk), .ce(ce), .num(c_md_r), .den(c_den2_r), .quo(qd), .ovf(ovfd), .nz(nzd)
  );
  vpt_div #(.NW(DEP_NW), .DW(DEN_W), .QW(QUO_W)) u_div_i (
    .clk(clk), .ce(ce), .num(INV_NUM), .den(c_den1_r), .quo(qi), .ovf(ovfi), .nz(nzi)
  );

  // sideband and valid bits ride alongside the divider stages
  logic  dv_r   [LAT];
  side_t side_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) dv_r[i] <= 1'b0;
    end else if (ce) begin
      dv_r[0] <= c_valid_r;
      for (int i = 1; i < LAT; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= c_side_r;
      for (int i = 1; i < LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---- saturation and output / skid registers ----
  side_t    fin;
  vtx_out_t res_c;
  logic     take;
  assign fin  = side_r[LAT-1];
  assign take = ce && dv_r[LAT-1];

  always_comb begin
    res_c.screen_x  = sat16(qx, ovfx, nzx, fin.nx);
    res_c.screen_y  = sat16(qy, ovfy, nzy, fin.ny);
    res_c.depth     = sat32(qd, ovfd, nzd, fin.nd);
    res_c.inv_w     = sat32(qi, ovfi, nzi, fin.wneg);
    res_c.div_fault = fin.wzero;
  end

  logic     out_valid_r;
  vtx_out_t out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_c;
    end else if (take) begin
      skid_data_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  `VPT_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r)
  `VPT_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r)
  `VPT_ASSERT_NEXT(a_skid_catches, out_valid_r && out_stall && take, skid_valid_r)
  `VPT_ASSERT_NOW(a_fault_inv_max, out_valid_r && out_data_r.div_fault,
                  out_data_r.inv_w == 32'sh7fffffff)

endmodule

FILE: src/vpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow
// and nonzero-numerator flags. Standalone; no package needed.
module vpt_div #(
  parameter int NW = 65,
  parameter int DW = 33,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic          nz
);

  localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [XW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic          nz_r  [QW+1];

  // entry stage: overflow when the quotient would not fit QW bits
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= XW'(num);
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= (XW'(num) >> QW) >= XW'(den);
      nz_r[0]  <= |num;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [XW-1:0] sh;
    logic          fits;
    assign sh   = XW'(den_r[k]) << (QW - 1 - k);
    assign fits = rem_r[k] >= sh;
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+1] <= fits ? (rem_r[k] - sh) : rem_r[k];
        den_r[k+1] <= den_r[k];
        q_r[k+1]   <= q_r[k] | (fits ? (QW'(1) << (QW - 1 - k)) : '0);
        ovf_r[k+1] <= ovf_r[k];
        nz_r[k+1]  <= nz_r[k];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];
  assign nz  = nz_r[QW];

endmodule
